// File: hw/rtl/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg: shared definitions for the fractional delay line
// Field widths, register indexes and default sizes of the block.
// ----------------------------------------------------------------------------
package fdl_pkg;

	// Fixed widths of the configuration fields.
	localparam int unsigned LEN_FIELD_W   = 13;
	localparam int unsigned DELAY_W       = 28;
	localparam int unsigned CFG_DATA_W    = 28;

	// Defaults for the top-level parameters.
	localparam int unsigned MAX_DEPTH_DEF    = 4096;
	localparam int unsigned SAMPLE_WIDTH_DEF = 24;
	localparam int unsigned FRAC_BITS_DEF    = 16;

	// Store length after reset, before limiting to the store depth.
	localparam int unsigned LEN_RESET = 4096;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_BUFFER_LENGTH = 1'b0,
		REG_DELAY_SAMPLES = 1'b1
	} cfg_reg_t;

endpackage

// File: hw/rtl/fractional_delay_line_top.sv
// ----------------------------------------------------------------------------
// fractional_delay_line_top: fractional delay with linear interpolation
// A circular sample store with one write and two read ports feeds an
// interpolation pipeline that blends two neighboring delayed samples.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload                    direction
//  -------   ------------------   ------------------------   ---------
//  input     in_valid / in_stall  sample_in                  into block
//  output    out_valid/out_stall  sample_out                 out of block
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data        into block
//
// One sample is taken every cycle while in_stall is low. Each result passes
// through registered steps in order: the memory read, the operand select
// and subtract, the multiply, and the final add into the output register.
// The sample store is one memory with a write port and two read ports,
// and it sets the rate.
// Reset and a write of buffer_length clear the store without a clearing
// pass: a fill count records how many samples were written since, and
// reads of entries not yet written return zero.
// A stalled output holds its result; the stages behind it keep filling
// until each holds an item, and only then is in_stall raised.
// ----------------------------------------------------------------------------
module fractional_delay_line_top #(
	parameter int unsigned MAX_DEPTH    = fdl_pkg::MAX_DEPTH_DEF,
	parameter int unsigned SAMPLE_WIDTH = fdl_pkg::SAMPLE_WIDTH_DEF,
	parameter int unsigned FRAC_BITS    = fdl_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Sample input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
	// Sample output channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  fdl_pkg::cfg_reg_t                 cfg_index,
	input  logic [fdl_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fdl_pkg::*;

	localparam int unsigned ADDR_W = $clog2(MAX_DEPTH);
	localparam int unsigned LEN_W  = $clog2(MAX_DEPTH + 1);
	localparam int unsigned DIFF_W = SAMPLE_WIDTH + 1;
	localparam int unsigned PROD_W = DIFF_W + FRAC_BITS + 1;
	localparam int unsigned DI_W   = DELAY_W - FRAC_BITS;
	localparam int unsigned SC_W   = (DI_W > ADDR_W) ? DI_W : ADDR_W;
	localparam int unsigned CL_W   = (LEN_FIELD_W > LEN_W) ? LEN_FIELD_W : LEN_W;
	localparam int unsigned LEN_RST = (LEN_RESET > MAX_DEPTH) ? MAX_DEPTH : LEN_RESET;

	// ------------------------------------------------------------------
	// Configuration and pointer state
	// ------------------------------------------------------------------
	logic [DELAY_W-1:0]    delay_q;
	logic [LEN_W-1:0]      len_q;
	logic [ADDR_W-1:0]     lenm1_q;
	logic [ADDR_W-1:0]     dint_q;     // saturated whole delay
	logic [FRAC_BITS-1:0]  frac_q;     // saturated fraction
	logic                  zero_q;     // whole delay is zero
	logic                  last_q;     // whole delay is length minus one
	logic [ADDR_W-1:0]     pos_q;      // write pointer
	logic [ADDR_W-1:0]     rd1_q;      // read pointer at the whole delay
	logic [ADDR_W-1:0]     rd2_q;      // read pointer one sample older
	logic [LEN_W-1:0]      fill_q;     // samples written since the last clear

	logic in_acc;
	logic rdy1, rdy2, rdy3, rdy_o;

	// Candidate settings: the register being written replaces its current
	// value, and a length write also moves the write pointer home.
	logic [CL_W-1:0]       len_ext;
	logic [LEN_W-1:0]      len_c;
	logic [ADDR_W-1:0]     lenm1_c;
	logic [DELAY_W-1:0]    delay_c;
	logic [ADDR_W-1:0]     pos_c;
	logic [SC_W-1:0]       raw_ext;
	logic [SC_W-1:0]       lim_ext;
	logic [FRAC_BITS-1:0]  raw_frac;
	logic                  over_c;
	logic [ADDR_W-1:0]     dint_c;
	logic [FRAC_BITS-1:0]  frac_c;
	logic [ADDR_W:0]       sum_c;
	logic [ADDR_W:0]       len_wide;
	logic [ADDR_W-1:0]     rd1_c;
	logic [ADDR_W-1:0]     rd2_c;
	logic                  len_wr;
	logic                  dly_wr;

	assign cfg_ready = 1'b1;

	always_comb begin
		len_wr = 1'b0;
		dly_wr = 1'b0;
		if (cfg_valid) begin
			unique case (cfg_index)
				REG_BUFFER_LENGTH: len_wr = 1'b1;
				REG_DELAY_SAMPLES: dly_wr = 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		// A length outside the store's range is pulled to its nearer end.
		len_ext = CL_W'(cfg_data[LEN_FIELD_W-1:0]);
		if (len_ext < CL_W'(2)) begin
			len_c = LEN_W'(2);
		end else if (len_ext > CL_W'(MAX_DEPTH)) begin
			len_c = LEN_W'(MAX_DEPTH);
		end else begin
			len_c = LEN_W'(len_ext);
		end
		if (!len_wr) begin
			len_c = len_q;
		end
		lenm1_c = ADDR_W'(len_c - LEN_W'(1));
		delay_c = dly_wr ? cfg_data[DELAY_W-1:0] : delay_q;
		pos_c   = len_wr ? '0 : pos_q;

		// A delay beyond the last entry becomes exactly length minus one.
		raw_ext  = SC_W'(delay_c[DELAY_W-1:FRAC_BITS]);
		lim_ext  = SC_W'(lenm1_c);
		raw_frac = delay_c[FRAC_BITS-1:0];
		over_c   = (raw_ext > lim_ext) || ((raw_ext == lim_ext) && (raw_frac != '0));
		dint_c   = over_c ? lenm1_c : ADDR_W'(raw_ext);
		frac_c   = over_c ? '0 : raw_frac;

		// Read pointers relative to the write pointer, wrapped at the length.
		len_wide = (ADDR_W + 1)'(len_c);
		sum_c    = {1'b0, pos_c} + {1'b0, dint_c};
		rd1_c    = (sum_c >= len_wide) ? ADDR_W'(sum_c - len_wide) : ADDR_W'(sum_c);
		rd2_c    = (rd1_c == lenm1_c) ? '0 : rd1_c + ADDR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			len_q   <= LEN_W'(LEN_RST);
			lenm1_q <= ADDR_W'(LEN_RST - 1);
			dint_q  <= '0;
			frac_q  <= '0;
			zero_q  <= 1'b1;
			last_q  <= 1'b0;
			pos_q   <= '0;
			rd1_q   <= '0;
			rd2_q   <= ADDR_W'(1);
			fill_q  <= '0;
		end else if (len_wr || dly_wr) begin
			delay_q <= delay_c;
			len_q   <= len_c;
			lenm1_q <= lenm1_c;
			dint_q  <= dint_c;
			frac_q  <= frac_c;
			zero_q  <= (dint_c == '0);
			last_q  <= (dint_c == lenm1_c);
			pos_q   <= pos_c;
			rd1_q   <= rd1_c;
			rd2_q   <= rd2_c;
			if (len_wr) begin
				fill_q <= '0;
			end
		end else if (in_acc) begin
			// All three pointers step down together, wrapping at the length.
			pos_q <= (pos_q == '0) ? lenm1_q : pos_q - ADDR_W'(1);
			rd1_q <= (rd1_q == '0) ? lenm1_q : rd1_q - ADDR_W'(1);
			rd2_q <= (rd2_q == '0) ? lenm1_q : rd2_q - ADDR_W'(1);
			if (fill_q != len_q) begin
				fill_q <= fill_q + LEN_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: a stage loads when it is empty or its
	// contents move on in the same cycle.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, out_valid_q;

	assign rdy_o    = !out_valid_q || !out_stall;
	assign rdy3     = !v_s3 || rdy_o;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign in_acc   = in_valid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_acc;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy_o) out_valid_q <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Sample store. The newest sample is written while both taps are
	// read; a tap that lands on the entry being written takes the input
	// sample directly instead.
	// ------------------------------------------------------------------
	logic [SAMPLE_WIDTH-1:0] store [MAX_DEPTH];
	logic [SAMPLE_WIDTH-1:0] rdat1_s1, rdat2_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			store[pos_q] <= sample_in;
		end
		if (rdy1) begin
			rdat1_s1 <= store[rd1_q];
			rdat2_s1 <= store[rd2_q];
		end
	end

	// Stage 1: tap qualifiers travel with the read data.
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic [FRAC_BITS-1:0]           frac_s1;
	logic                           fwd1_s1, fwd2_s1, ok1_s1, ok2_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sample_s1 <= sample_in;
			frac_s1   <= frac_q;
			fwd1_s1   <= zero_q;
			fwd2_s1   <= last_q;
			// A tap is valid once the entry was written since the last clear.
			ok1_s1    <= (LEN_W'(dint_q) <= fill_q);
			ok2_s1    <= (LEN_W'(dint_q) < fill_q) || last_q;
		end
	end

	// Stage 2: pick the tap values and form their difference.
	logic signed [SAMPLE_WIDTH-1:0] tap1, tap2;
	logic signed [SAMPLE_WIDTH-1:0] v1_s2;
	logic signed [DIFF_W-1:0]       diff_s2;
	logic [FRAC_BITS-1:0]           frac_s2;

	always_comb begin
		tap1 = fwd1_s1 ? sample_s1 : $signed(rdat1_s1);
		tap2 = fwd2_s1 ? sample_s1 : $signed(rdat2_s1);
		if (!ok1_s1) tap1 = '0;
		if (!ok2_s1) tap2 = '0;
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			v1_s2   <= tap1;
			diff_s2 <= DIFF_W'(tap2) - DIFF_W'(tap1);
			frac_s2 <= frac_s1;
		end
	end

	// Stage 3: weight the difference by the fraction.
	logic signed [SAMPLE_WIDTH-1:0] v1_s3;
	logic signed [PROD_W-1:0]       prod_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			v1_s3   <= v1_s2;
			prod_s3 <= PROD_W'(diff_s2) * PROD_W'($signed({1'b0, frac_s2}));
		end
	end

	// Output register: the arithmetic shift floors the weighted step, and
	// the sum always lies between the two taps, so it fits the sample width.
	logic signed [PROD_W-1:0]       step;
	logic signed [SAMPLE_WIDTH-1:0] res_q;

	assign step = prod_s3 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (rdy_o) begin
			res_q <= v1_s3 + step[SAMPLE_WIDTH-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = res_q;

endmodule
